// File: rtl/sbbf_pkg.sv
// Shared types and constants for the split block Bloom filter.
// Used by sbbf_ctrl, sbbf_datapath, the top level and the checker; depends on nothing.
package sbbf_pkg;

    localparam int WORD_W     = 32;
    localparam int LANES      = 8;
    localparam int WORDS_PER_BLOCK = LANES;
    localparam int LANE_W     = 3;
    localparam int ROW_BITS   = WORD_W * LANES;
    localparam int HALF_W     = 32;
    localparam int SALT_SHIFT = 27;
    localparam int NB_W       = 11;
    localparam logic [NB_W-1:0] NB_RESET = 11'd1024;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TEST   = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;

    localparam logic [WORD_W-1:0] SALTS [LANES] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic calc;
        logic load_we;
        logic read;
        logic ins_we;
        logic res_load;
        logic clear_we;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic op_insert;
        logic op_test;
        logic op_load;
        logic out_busy;
    } sts_t;

endpackage

// File: rtl/split_block_bloom_filter_top.sv
// Top level of the split block Bloom filter.
// Depends on sbbf_pkg, sbbf_ctrl and sbbf_datapath.
//
// The input channel (in_valid / in_stall) carries one item: an insert or a test of a
// precomputed 64-bit hash, or a load of one raw 32-bit filter word. The output channel
// (out_valid / out_stall) carries one maybe_present bit for each test; inserts and loads
// give no result. cfg_we writes the block count num_blocks; write it only while idle.
// An insert or test runs through capture, hash arithmetic, block read, then the write
// back or the compare, all on the one 256-bit wide block memory, before the next item
// is accepted. A test result is loaded into the output register in the compare step.
// A load or an unknown operation runs through capture and the hash arithmetic step only.
// After reset the block sweeps the memory to zero, one block per cycle, from block 0
// to block MAX_BLOCKS-1; in_stall stays high until the sweep ends.
// When the receiver stalls, a result holds in the output register and the block keeps
// taking items; a further test waits in its last step until the register frees up.
module split_block_bloom_filter_top #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [sbbf_pkg::NB_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic [63:0]               hash,
    input  logic [12:0]               word_index,
    input  logic [31:0]               word_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      maybe_present
);

    sbbf_pkg::cmd_t cmd;
    sbbf_pkg::sts_t sts;

    sbbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbbf_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .hash          (hash),
        .word_index    (word_index),
        .word_data     (word_data),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .maybe_present (maybe_present)
    );

endmodule

// File: rtl/sbbf_ctrl.sv
// Controller state machine of the split block Bloom filter.
// Depends on sbbf_pkg for the command and status structs.
module sbbf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sbbf_pkg::sts_t sts,
    output sbbf_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc    = 1'b1;
                cmd.load_we = sts.op_load;
                if (sts.op_insert || sts.op_test)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.op_insert)
                begin
                    cmd.ins_we = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!sts.out_busy)
                begin
                    // A test result waits here until the output register is free.
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sbbf_datapath.sv
// Datapath of the split block Bloom filter: hash arithmetic, block memory, output register.
// Depends on sbbf_pkg for constants, salts and the command and status structs.
module sbbf_datapath #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sbbf_pkg::NB_W-1:0]     cfg_data,
    input  logic [1:0]                    operation,
    input  logic [63:0]                   hash,
    input  logic [12:0]                   word_index,
    input  logic [31:0]                   word_data,
    input  logic                          out_stall,
    input  sbbf_pkg::cmd_t                cmd,
    output sbbf_pkg::sts_t                sts,
    output logic                          out_valid,
    output logic                          maybe_present
);

    localparam int ROW_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W      = sbbf_pkg::HALF_W + CNT_W;
    localparam int STORE_WORDS = MAX_BLOCKS * sbbf_pkg::WORDS_PER_BLOCK;
    localparam int WW          = sbbf_pkg::WORD_W;
    localparam int LN          = sbbf_pkg::LANES;
    localparam int RB          = sbbf_pkg::ROW_BITS;

    logic [sbbf_pkg::NB_W-1:0] num_blocks_reg;
    logic [1:0]                op_reg;
    logic [63:0]               hash_reg;
    logic [12:0]               widx_reg;
    logic [31:0]               wdata_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;
    logic [RB-1:0]             mask_reg;
    logic [RB-1:0]             mask_next;
    logic [RB-1:0]             rd_data_reg;
    logic [ROW_W-1:0]          clr_cnt_reg;
    logic                      out_valid_reg;
    logic                      maybe_reg;

    logic [RB-1:0]             mem [MAX_BLOCKS];

    logic [31:0]               nb_wide;
    logic [31:0]               nb_clamp;
    logic [CNT_W-1:0]          blocks;
    logic [PROD_W-1:0]         blk_prod;
    logic [CNT_W-1:0]          blk;
    logic [WW-1:0]             salt_prod [LN];
    logic [31:0]               widx_wide;
    logic                      load_ok;
    logic [ROW_W-1:0]          load_row;
    logic                      mem_we;
    logic [LN-1:0]             mem_wen;
    logic [ROW_W-1:0]          mem_waddr;
    logic [RB-1:0]             mem_wdata;
    logic                      hit;

    // Configuration, captured item fields and the calculated row and mask.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg <= sbbf_pkg::NB_RESET;
        end
        else if (cfg_we)
        begin
            num_blocks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            hash_reg  <= hash;
            widx_reg  <= word_index;
            wdata_reg <= word_data;
        end
        if (cmd.calc)
        begin
            row_reg  <= row_next;
            mask_reg <= mask_next;
        end
    end

    // Block select: upper hash half times the clamped block count, product bits above the low 32.
    always_comb
    begin
        nb_wide = 32'(num_blocks_reg);
        if (nb_wide == 32'd0)
        begin
            nb_clamp = 32'd1;
        end
        else if (nb_wide > 32'(MAX_BLOCKS))
        begin
            nb_clamp = 32'(MAX_BLOCKS);
        end
        else
        begin
            nb_clamp = nb_wide;
        end
        blocks   = nb_clamp[CNT_W-1:0];
        blk_prod = PROD_W'(hash_reg[63:32]) * PROD_W'(blocks);
        blk      = blk_prod[PROD_W-1:sbbf_pkg::HALF_W];
        if (32'(blk) >= 32'(MAX_BLOCKS))
        begin
            row_next = ROW_W'(MAX_BLOCKS - 1);
        end
        else
        begin
            row_next = ROW_W'(blk);
        end
    end

    // One salted bit per 32-bit word of the block.
    always_comb
    begin
        for (int l = 0; l < LN; l++)
        begin
            salt_prod[l] = hash_reg[31:0] * sbbf_pkg::SALTS[l];
            mask_next[l*WW +: WW] = 32'd1 << salt_prod[l][WW-1:sbbf_pkg::SALT_SHIFT];
        end
    end

    // Load target.
    always_comb
    begin
        widx_wide = 32'(widx_reg);
        load_ok   = (widx_wide < 32'(STORE_WORDS));
        load_row  = ROW_W'(widx_wide >> sbbf_pkg::LANE_W);
    end

    // Single write port shared by the clearing pass, loads and inserts.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wen   = '0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (cmd.clear_we)
        begin
            mem_we  = 1'b1;
            mem_wen = '1;
        end
        else if (cmd.load_we && load_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = load_row;
            mem_wen   = LN'(1) << widx_reg[sbbf_pkg::LANE_W-1:0];
            mem_wdata = {LN{wdata_reg}};
        end
        else if (cmd.ins_we)
        begin
            mem_we    = 1'b1;
            mem_waddr = row_reg;
            mem_wen   = '1;
            mem_wdata = rd_data_reg | mask_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            for (int l = 0; l < LN; l++)
            begin
                if (mem_wen[l])
                begin
                    mem[mem_waddr][l*WW +: WW] <= mem_wdata[l*WW +: WW];
                end
            end
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[row_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_we)
        begin
            clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
        end
    end

    always_comb
    begin
        hit = 1'b1;
        for (int l = 0; l < LN; l++)
        begin
            if ((rd_data_reg[l*WW +: WW] & mask_reg[l*WW +: WW]) == '0)
            begin
                hit = 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            maybe_reg <= hit;
        end
    end

    assign out_valid     = out_valid_reg;
    assign maybe_present = maybe_reg;

    assign sts.clear_last = (clr_cnt_reg == ROW_W'(MAX_BLOCKS - 1));
    assign sts.op_insert  = (op_reg == sbbf_pkg::OP_INSERT);
    assign sts.op_test    = (op_reg == sbbf_pkg::OP_TEST);
    assign sts.op_load    = (op_reg == sbbf_pkg::OP_LOAD);
    assign sts.out_busy   = out_valid_reg && out_stall;

endmodule

// File: rtl/sbbf_checker.sv
// Port-level checks for split_block_bloom_filter_top, attached by the bind below.
// Depends on sbbf_pkg for the operation codes.
module sbbf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  operation,
    input logic        out_valid,
    input logic        out_stall,
    input logic        maybe_present
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(maybe_present))
        else $error("stalled result changed");

    // Every accepted item keeps the input stalled for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item was in progress");

    // A fresh result comes from an earlier accepted test.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && !in_stall && (operation == sbbf_pkg::OP_TEST), 4))
        else $error("result without a matching test");

    // Inserts, loads and unknown operations never produce a result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (operation != sbbf_pkg::OP_TEST) |-> ##4 !$rose(out_valid))
        else $error("result produced by a non-test item");

endmodule

bind split_block_bloom_filter_top sbbf_checker u_sbbf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .maybe_present (maybe_present)
);
